// File: rtl/core/hll_riemann_flux_macros.svh
// assertion helpers for the hll flux block
`ifndef HLL_RIEMANN_FLUX_MACROS_SVH
`define HLL_RIEMANN_FLUX_MACROS_SVH

// condition holds in the same cycle
`define HRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define HRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hrf_pkg.sv
`default_nettype none

package hrf_pkg;

  // default word format, signed q16.16
  localparam int HRF_WORD_BITS = 32;
  localparam int HRF_FRAC_BITS = 16;

  // sampled region of the wave fan
  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_STAR  = 2'd1,
    REG_RIGHT = 2'd2
  } region_t;

endpackage

`default_nettype wire

// File: rtl/core/hll_riemann_flux.sv
// hll approximate riemann flux, one conserved component per word
//
// input channel (in_valid / in_ready): one word carries the four side speeds,
// left and right conserved value and flux, and the sampling speed, all
// signed fixed point with FRAC_BITS fraction bits
// output channel (out_valid / out_ready): one word per input word, in order,
// with the sampled value and flux, the outer speeds, the region code, the
// degenerate flag (equal outer speeds) and the saturation flag
//
// a new word can be taken every cycle while the skid register is empty. the
// restoring divider retires one quotient bit per pipeline stage for both the
// star value and the star flux, after five stages of outer speeds, products,
// sums and magnitudes
//
// a skid register behind the output register absorbs one word when the
// receiver stalls; the whole pipe then holds and in_ready drops until the
// skid drains. nothing is lost or repeated across a stall
// reset clears all valid bits; the pipe is empty and ready right after reset
`default_nettype none

module hll_riemann_flux
  import hrf_pkg::*;
#(
  parameter int WORD_BITS = HRF_WORD_BITS,
  parameter int FRAC_BITS = HRF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [WORD_BITS-1:0] left_slow_speed,
  input  wire logic signed [WORD_BITS-1:0] left_fast_speed,
  input  wire logic signed [WORD_BITS-1:0] right_slow_speed,
  input  wire logic signed [WORD_BITS-1:0] right_fast_speed,
  input  wire logic signed [WORD_BITS-1:0] cons_left,
  input  wire logic signed [WORD_BITS-1:0] cons_right,
  input  wire logic signed [WORD_BITS-1:0] flux_left,
  input  wire logic signed [WORD_BITS-1:0] flux_right,
  input  wire logic signed [WORD_BITS-1:0] sample_speed,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      cons_out,
  output logic signed [WORD_BITS-1:0]      flux_out,
  output logic signed [WORD_BITS-1:0]      speed_min,
  output logic signed [WORD_BITS-1:0]      speed_max,
  output logic [1:0]                       region,
  output logic                             degenerate,
  output logic                             saturated
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // speed times value
  localparam int AW  = 2 * W + 1;      // difference of two products
  localparam int NUW = 2 * W + F + 3;  // star value numerator
  localparam int NFW = 3 * W + F + 4;  // star flux numerator
  localparam int DNW = NFW;            // divider dividend
  localparam int DW  = W + 1;          // divider divisor and remainder

  // fields that ride along with the divider
  typedef struct packed {
    logic signed [W-1:0] am;
    logic signed [W-1:0] ap;
    logic signed [W-1:0] ul;
    logic signed [W-1:0] ur;
    logic signed [W-1:0] fl;
    logic signed [W-1:0] fr;
    region_t             reg_code;
    logic                degen;
  } side_t;

  typedef struct packed {
    logic signed [W-1:0] cons;
    logic signed [W-1:0] flux;
    logic signed [W-1:0] am;
    logic signed [W-1:0] ap;
    region_t             reg_code;
    logic                degen;
    logic                sat;
  } res_t;

  // whole pipe advances unless the skid register is occupied
  logic en;
  logic k_v;
  logic o_v;
  res_t o_res;
  res_t k_res;

  assign en       = !k_v;
  assign in_ready = en;

  // stage 1: outer speeds
  logic                v1;
  logic signed [W-1:0] s1_am, s1_ap, s1_ul, s1_ur, s1_fl, s1_fr, s1_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_am <= (left_slow_speed < right_slow_speed) ? left_slow_speed : right_slow_speed;
      s1_ap <= (left_fast_speed > right_fast_speed) ? left_fast_speed : right_fast_speed;
      s1_ul <= cons_left;
      s1_ur <= cons_right;
      s1_fl <= flux_left;
      s1_fr <= flux_right;
      s1_s  <= sample_speed;
    end
  end

  // stage 2: region pick, products, differences
  logic                 v2;
  side_t                s2_sd;
  logic signed [W:0]    s2_den, s2_du, s2_df;
  logic signed [PW-1:0] s2_apur, s2_amul, s2_apfl, s2_amfr, s2_apam;
  region_t              reg_pick;

  always_comb begin
    if (s1_s <= s1_am) begin
      reg_pick = REG_LEFT;
    end else if (s1_s <= s1_ap) begin
      reg_pick = REG_STAR;
    end else begin
      reg_pick = REG_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sd.am       <= s1_am;
      s2_sd.ap       <= s1_ap;
      s2_sd.ul       <= s1_ul;
      s2_sd.ur       <= s1_ur;
      s2_sd.fl       <= s1_fl;
      s2_sd.fr       <= s1_fr;
      s2_sd.reg_code <= reg_pick;
      s2_sd.degen    <= (s1_am == s1_ap);
      s2_den  <= {s1_ap[W-1], s1_ap} - {s1_am[W-1], s1_am};
      s2_du   <= {s1_ur[W-1], s1_ur} - {s1_ul[W-1], s1_ul};
      s2_df   <= {s1_fl[W-1], s1_fl} - {s1_fr[W-1], s1_fr};
      s2_apur <= s1_ap * s1_ur;
      s2_amul <= s1_am * s1_ul;
      s2_apfl <= s1_ap * s1_fl;
      s2_amfr <= s1_am * s1_fr;
      s2_apam <= s1_ap * s1_am;
    end
  end

  // stage 3: value numerator, flux partial products
  logic                  v3;
  side_t                 s3_sd;
  logic signed [W:0]     s3_den;
  logic signed [NUW-1:0] s3_nu;
  logic signed [AW-1:0]  s3_a;
  logic signed [PW:0]    s3_mh;   // high half of ap*am times du
  logic signed [PW+1:0]  s3_ml;   // low half of ap*am times du

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sd  <= s2_sd;
      s3_den <= s2_den;
      s3_nu  <= NUW'(s2_apur) - NUW'(s2_amul) + (NUW'(s2_df) <<< F);
      s3_a   <= AW'(s2_apfl) - AW'(s2_amfr);
      s3_mh  <= $signed(s2_apam[PW-1:W]) * s2_du;
      s3_ml  <= $signed({1'b0, s2_apam[W-1:0]}) * s2_du;
    end
  end

  // stage 4: flux numerator
  logic                  v4;
  side_t                 s4_sd;
  logic signed [W:0]     s4_den;
  logic signed [NUW-1:0] s4_nu;
  logic signed [NFW-1:0] s4_nf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sd  <= s3_sd;
      s4_den <= s3_den;
      s4_nu  <= s3_nu;
      s4_nf  <= (NFW'(s3_a) <<< F) + (NFW'(s3_mh) <<< W) + NFW'(s3_ml);
    end
  end

  // stage 5: magnitudes and signs for the unsigned divider
  logic            v5;
  side_t           s5_sd;
  logic [DW-1:0]   s5_d;
  logic [DNW-1:0]  s5_nu_mag, s5_nf_mag;
  logic            s5_neg_u, s5_neg_f;
  logic [NUW-1:0]  nu_abs;
  logic [NFW-1:0]  nf_abs;

  assign nu_abs = s4_nu[NUW-1] ? NUW'(-s4_nu) : NUW'(s4_nu);
  assign nf_abs = s4_nf[NFW-1] ? NFW'(-s4_nf) : NFW'(s4_nf);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sd     <= s4_sd;
      s5_d      <= s4_den[DW-1:0];
      s5_nu_mag <= DNW'(nu_abs);
      // dividing by den * 2^F equals dropping F bits, then dividing by den
      s5_nf_mag <= DNW'(nf_abs >> F);
      s5_neg_u  <= s4_nu[NUW-1];
      s5_neg_f  <= s4_nf[NFW-1];
    end
  end

  // divider: stage 0 checks for a quotient of more than W bits, then one
  // quotient bit per stage for value and flux side by side
  logic          dv   [0:W];
  side_t         dsd  [0:W];
  logic [DW-1:0] dd   [0:W];
  logic [DW-1:0] dru  [0:W];
  logic [DW-1:0] drf  [0:W];
  logic [W-1:0]  dnu  [0:W];
  logic [W-1:0]  dnf  [0:W];
  logic [W-1:0]  dqu  [0:W];
  logic [W-1:0]  dqf  [0:W];
  logic          dovu [0:W];
  logic          dovf [0:W];
  logic          dngu [0:W];
  logic          dngf [0:W];

  logic [DNW-W-1:0] hi_u, hi_f;

  assign hi_u = s5_nu_mag[DNW-1:W];
  assign hi_f = s5_nf_mag[DNW-1:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsd[0]  <= s5_sd;
      dd[0]   <= s5_d;
      dovu[0] <= (hi_u >= (DNW-W)'(s5_d));
      dovf[0] <= (hi_f >= (DNW-W)'(s5_d));
      dru[0]  <= hi_u[DW-1:0];
      drf[0]  <= hi_f[DW-1:0];
      dnu[0]  <= s5_nu_mag[W-1:0];
      dnf[0]  <= s5_nf_mag[W-1:0];
      dqu[0]  <= '0;
      dqf[0]  <= '0;
      dngu[0] <= s5_neg_u;
      dngf[0] <= s5_neg_f;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [DW:0]   r2u, r2f;
    logic          geu, gef;

    assign r2u = {dru[k], dnu[k][W-1]};
    assign r2f = {drf[k], dnf[k][W-1]};
    assign geu = (r2u >= {1'b0, dd[k]});
    assign gef = (r2f >= {1'b0, dd[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsd[k+1]  <= dsd[k];
        dd[k+1]   <= dd[k];
        dovu[k+1] <= dovu[k];
        dovf[k+1] <= dovf[k];
        dngu[k+1] <= dngu[k];
        dngf[k+1] <= dngf[k];
        dnu[k+1]  <= dnu[k] << 1;
        dnf[k+1]  <= dnf[k] << 1;
        dru[k+1]  <= geu ? DW'(r2u - {1'b0, dd[k]}) : r2u[DW-1:0];
        drf[k+1]  <= gef ? DW'(r2f - {1'b0, dd[k]}) : r2f[DW-1:0];
        dqu[k+1]  <= {dqu[k][W-2:0], geu};
        dqf[k+1]  <= {dqf[k][W-2:0], gef};
      end
    end
  end

  // sign, clamp and final selection
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic                sat_u, sat_f;
  logic signed [W-1:0] star_u, star_f;
  res_t                p_res;

  always_comb begin
    if (!dngu[W]) begin
      sat_u  = dovu[W] || dqu[W][W-1];
      star_u = sat_u ? MAXV : $signed(dqu[W]);
    end else begin
      sat_u  = dovu[W] || (dqu[W][W-1] && (|dqu[W][W-2:0]));
      star_u = sat_u ? MINV : $signed(-dqu[W]);
    end
    if (!dngf[W]) begin
      sat_f  = dovf[W] || dqf[W][W-1];
      star_f = sat_f ? MAXV : $signed(dqf[W]);
    end else begin
      sat_f  = dovf[W] || (dqf[W][W-1] && (|dqf[W][W-2:0]));
      star_f = sat_f ? MINV : $signed(-dqf[W]);
    end

    p_res.am       = dsd[W].am;
    p_res.ap       = dsd[W].ap;
    p_res.reg_code = dsd[W].reg_code;
    p_res.degen    = dsd[W].degen;
    unique case (dsd[W].reg_code)
      REG_LEFT: begin
        p_res.cons = dsd[W].ul;
        p_res.flux = dsd[W].fl;
        p_res.sat  = 1'b0;
      end
      REG_STAR: begin
        p_res.cons = star_u;
        p_res.flux = star_f;
        p_res.sat  = sat_u || sat_f;
      end
      default: begin
        p_res.cons = dsd[W].ur;
        p_res.flux = dsd[W].fr;
        p_res.sat  = 1'b0;
      end
    endcase
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      k_v <= 1'b0;
    end else if (en) begin
      if (!o_v || out_ready) begin
        o_v <= dv[W];
      end else if (dv[W]) begin
        k_v <= 1'b1;
      end
    end else if (out_ready) begin
      k_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!o_v || out_ready) begin
        o_res <= p_res;
      end else begin
        k_res <= p_res;
      end
    end else if (out_ready) begin
      o_res <= k_res;
    end
  end

  assign out_valid  = o_v;
  assign cons_out   = o_res.cons;
  assign flux_out   = o_res.flux;
  assign speed_min  = o_res.am;
  assign speed_max  = o_res.ap;
  assign region     = 2'(o_res.reg_code);
  assign degenerate = o_res.degen;
  assign saturated  = o_res.sat;

  // checks
  `include "hll_riemann_flux_macros.svh"

  `HRF_ASSERT_NOW(a_degen_not_star, out_valid && degenerate, region != REG_STAR, "star region with equal outer speeds")
  `HRF_ASSERT_NOW(a_sat_only_star, out_valid && saturated, region == REG_STAR, "saturation outside star region")
  `HRF_ASSERT_NOW(a_star_speeds, out_valid && region == REG_STAR, speed_min < speed_max, "star region with crossed speeds")
  `HRF_ASSERT_NOW(a_skid_behind_out, k_v, o_v, "skid word held with empty output register")
  `HRF_ASSERT_NEXT(a_skid_drains, k_v && out_ready, !k_v, "skid word not released")

endmodule

`default_nettype wire
